// File: rtl/core/ppt_pkg.sv
// Shared types and constants for the pedal plausibility / torque command block.
// Holds controller states, command/status structs, register indexes and reset values.
// No dependencies.
package ppt_pkg;

  localparam int PRESSURE_FULL_SCALE_DEF = 3000;
  localparam int PEDAL_SKEW_DEF          = 10;
  localparam int DEADBAND_DEF            = 10;

  localparam int RAW_W     = 10;
  localparam int SCL_W     = 8;
  localparam int BP_W      = 12;
  localparam int TQ_W      = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int LIM_W     = 12;
  localparam int GAIN_W    = 16;
  localparam int NUM_W     = RAW_W + SCL_W;
  localparam int DIVD_W    = 24;
  localparam int QUO_W     = 16;
  localparam int CNT_W     = 5;
  localparam int PROD_W    = 32;

  localparam int SCALE_MAX     = 255;
  localparam int TORQUE_SCALE  = 10;
  localparam int TRAVEL_FACTOR = 4;
  localparam int ADC_SHIFT     = 10;

  localparam logic [CNT_W-1:0] PEDAL_STEPS  = CNT_W'(SCL_W);
  localparam logic [CNT_W-1:0] TORQUE_STEPS = CNT_W'(QUO_W);

  localparam logic [RAW_W-1:0]  RST_FIRST_LOW   = RAW_W'(189);
  localparam logic [RAW_W-1:0]  RST_FIRST_HIGH  = RAW_W'(849);
  localparam logic [RAW_W-1:0]  RST_SECOND_LOW  = RAW_W'(50);
  localparam logic [RAW_W-1:0]  RST_SECOND_HIGH = RAW_W'(417);
  localparam logic [LIM_W-1:0]  RST_TORQUE_LIM  = LIM_W'(50);
  localparam logic [LIM_W-1:0]  RST_COAST       = LIM_W'(10);
  localparam logic [GAIN_W-1:0] RST_GAIN        = GAIN_W'(0);
  localparam logic [GAIN_W-1:0] RST_TRIP_LEVEL  = GAIN_W'(500);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_LOW,
    CFG_FIRST_HIGH,
    CFG_SECOND_LOW,
    CFG_SECOND_HIGH,
    CFG_TORQUE_LIM,
    CFG_COAST,
    CFG_GAIN,
    CFG_TRIP_LEVEL
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SEL_PEDAL0,
    SEL_PEDAL1,
    SEL_TORQUE
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_P0_GO,
    S_P0_WAIT,
    S_P1_GO,
    S_P1_WAIT,
    S_FAULT,
    S_MUL,
    S_TQ_GO,
    S_TQ_WAIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic     load_in;
    logic     div_start;
    div_sel_t div_sel;
    logic     store_s0;
    logic     store_s1;
    logic     fault_eval;
    logic     mul_go;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic drive;
  } sts_t;

endpackage

// File: rtl/core/ppt_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Divisor arrives pre-shifted to the top quotient bit. Uses ppt_pkg.
module ppt_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ppt_pkg::DIVD_W-1:0]   dividend,
  input  logic [ppt_pkg::DIVD_W-1:0]   divisor_sh,
  input  logic [ppt_pkg::CNT_W-1:0]    steps,
  output logic                         busy,
  output logic [ppt_pkg::QUO_W-1:0]    quotient
);
  import ppt_pkg::*;

  logic [DIVD_W-1:0] rem_r, rem_nxt;
  logic [DIVD_W-1:0] dsh_r, dsh_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ge;

  assign ge = (rem_r >= dsh_r);

  always_comb begin
    rem_nxt = rem_r;
    dsh_nxt = dsh_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = dividend;
      dsh_nxt = divisor_sh;
      quo_nxt = '0;
      cnt_nxt = steps;
    end else if (cnt_r != '0) begin
      rem_nxt = ge ? (rem_r - dsh_r) : rem_r;
      dsh_nxt = dsh_r >> 1;
      quo_nxt = {quo_r[QUO_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

endmodule

// File: rtl/core/ppt_dp.sv
// Datapath: config registers, sample registers, pedal scaling, fault checks,
// torque multiply/divide, brake scaling and trip latch. Uses ppt_pkg and ppt_div.
module ppt_dp #(
  parameter int PRESSURE_FULL_SCALE = ppt_pkg::PRESSURE_FULL_SCALE_DEF,
  parameter int PEDAL_SKEW          = ppt_pkg::PEDAL_SKEW_DEF,
  parameter int DEADBAND            = ppt_pkg::DEADBAND_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ppt_pkg::cmd_t                    cmd,
  output ppt_pkg::sts_t                    sts,
  input  logic                             cfg_we,
  input  logic [ppt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppt_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic [ppt_pkg::RAW_W-1:0]        in_first_pedal_raw,
  input  logic [ppt_pkg::RAW_W-1:0]        in_second_pedal_raw,
  input  logic [ppt_pkg::RAW_W-1:0]        in_first_brake_raw,
  input  logic [ppt_pkg::RAW_W-1:0]        in_second_brake_raw,
  input  logic [15:0]                      in_front_pressure,
  input  logic                             in_drive_ready,
  output logic [ppt_pkg::SCL_W-1:0]        out_first_pedal_scaled,
  output logic [ppt_pkg::SCL_W-1:0]        out_second_pedal_scaled,
  output logic [ppt_pkg::BP_W-1:0]         out_first_brake_pressure,
  output logic [ppt_pkg::BP_W-1:0]         out_second_brake_pressure,
  output logic                             out_brake_tripped,
  output logic signed [ppt_pkg::TQ_W-1:0]  out_torque_command,
  output logic                             out_ready_echo
);
  import ppt_pkg::*;

  localparam int BM_W = RAW_W + 16;
  localparam logic [RAW_W:0]      TRAVEL_MARGIN = (RAW_W+1)'(TRAVEL_FACTOR * PEDAL_SKEW);
  localparam logic [SCL_W:0]      SKEW_LIM      = (SCL_W+1)'(PEDAL_SKEW);
  localparam logic [SCL_W-1:0]    DB_LVL        = SCL_W'(DEADBAND);
  localparam logic [SCL_W-1:0]    TQ_DIV        = SCL_W'(SCALE_MAX - DEADBAND);
  localparam logic [BM_W-1:0]     PFS           = BM_W'(PRESSURE_FULL_SCALE);

  // configuration
  logic [RAW_W-1:0]  lo0_r, hi0_r, lo1_r, hi1_r;
  logic [LIM_W-1:0]  tlim_r, coast_r;
  logic [GAIN_W-1:0] gain_r, trip_lvl_r;

  // sample registers
  logic [RAW_W-1:0] p0_r, p1_r, b0_r, b1_r;
  logic [15:0]      front_r;
  logic             ready_r;

  // pedal scaling
  logic [RAW_W-1:0]  raw, lo, hi;
  logic [RAW_W:0]    dn, dd;
  logic [RAW_W-1:0]  dn_mag, dd_mag;
  logic [NUM_W-1:0]  num_mag;
  logic              pz, pov;
  logic              pz_r, pov_r;
  logic [SCL_W-1:0]  sres;
  logic [SCL_W-1:0]  s0_r, s1_r;

  // fault / average
  logic             travel, mismatch, bad;
  logic [SCL_W-1:0] f0, f1, avg;
  logic [SCL_W-1:0] sf0_r, sf1_r, avg_r;
  logic             drive_r;

  // torque
  logic [LIM_W-1:0]  dmul;
  logic [15:0]       mul_a, mul_b;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W:0]   regen_mag;
  logic [TQ_W-1:0]   tq;

  // divider
  logic [DIVD_W-1:0] div_dividend, div_divisor;
  logic [CNT_W-1:0]  div_steps;
  logic              div_busy;
  logic [QUO_W-1:0]  quotient;

  // brakes
  logic [BM_W-1:0]  bm0, bm1;
  logic [15:0]      bp0, bp1;
  logic [16:0]      bp_sum;
  logic             trip_r, trip_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo0_r      <= RST_FIRST_LOW;
      hi0_r      <= RST_FIRST_HIGH;
      lo1_r      <= RST_SECOND_LOW;
      hi1_r      <= RST_SECOND_HIGH;
      tlim_r     <= RST_TORQUE_LIM;
      coast_r    <= RST_COAST;
      gain_r     <= RST_GAIN;
      trip_lvl_r <= RST_TRIP_LEVEL;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FIRST_LOW:   lo0_r      <= cfg_wdata[RAW_W-1:0];
        CFG_FIRST_HIGH:  hi0_r      <= cfg_wdata[RAW_W-1:0];
        CFG_SECOND_LOW:  lo1_r      <= cfg_wdata[RAW_W-1:0];
        CFG_SECOND_HIGH: hi1_r      <= cfg_wdata[RAW_W-1:0];
        CFG_TORQUE_LIM:  tlim_r     <= cfg_wdata[LIM_W-1:0];
        CFG_COAST:       coast_r    <= cfg_wdata[LIM_W-1:0];
        CFG_GAIN:        gain_r     <= cfg_wdata[GAIN_W-1:0];
        CFG_TRIP_LEVEL:  trip_lvl_r <= cfg_wdata[GAIN_W-1:0];
        default:         lo0_r      <= lo0_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      p0_r    <= in_first_pedal_raw;
      p1_r    <= in_second_pedal_raw;
      b0_r    <= in_first_brake_raw;
      b1_r    <= in_second_brake_raw;
      front_r <= in_front_pressure;
      ready_r <= in_drive_ready;
    end
  end

  always_comb begin
    unique case (cmd.div_sel)
      SEL_PEDAL1: begin
        raw = p1_r;
        lo  = lo1_r;
        hi  = hi1_r;
      end
      default: begin
        raw = p0_r;
        lo  = lo0_r;
        hi  = hi0_r;
      end
    endcase
  end

  assign dn      = {1'b0, raw} - {1'b0, lo};
  assign dd      = {1'b0, hi} - {1'b0, lo};
  assign dn_mag  = dn[RAW_W] ? RAW_W'(~dn + (RAW_W+1)'(1)) : dn[RAW_W-1:0];
  assign dd_mag  = dd[RAW_W] ? RAW_W'(~dd + (RAW_W+1)'(1)) : dd[RAW_W-1:0];
  assign num_mag = {dn_mag, {SCL_W{1'b0}}} - {{SCL_W{1'b0}}, dn_mag};
  // zero range, or a negative ratio, clamps to zero
  assign pz      = (dd == '0) || (dn[RAW_W] != dd[RAW_W]);
  assign pov     = (num_mag >= {dd_mag, {SCL_W{1'b0}}});

  always_comb begin
    if (cmd.div_sel == SEL_TORQUE) begin
      div_dividend = prod_r[DIVD_W-1:0];
      div_divisor  = DIVD_W'({TQ_DIV, {(QUO_W-1){1'b0}}});
      div_steps    = TORQUE_STEPS;
    end else begin
      div_dividend = DIVD_W'(num_mag);
      div_divisor  = DIVD_W'({dd_mag, {(SCL_W-1){1'b0}}});
      div_steps    = PEDAL_STEPS;
    end
  end

  ppt_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (cmd.div_start),
    .dividend   (div_dividend),
    .divisor_sh (div_divisor),
    .steps      (div_steps),
    .busy       (div_busy),
    .quotient   (quotient)
  );

  assign sres = pz_r ? '0 : (pov_r ? SCL_W'(SCALE_MAX) : quotient[SCL_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.div_start && (cmd.div_sel != SEL_TORQUE)) begin
      pz_r  <= pz;
      pov_r <= pov;
    end
    if (cmd.store_s0) begin
      s0_r <= sres;
    end
    if (cmd.store_s1) begin
      s1_r <= sres;
    end
  end

  assign travel   = (p0_r < lo0_r) || ({1'b0, p0_r} > ({1'b0, hi0_r} + TRAVEL_MARGIN)) ||
                    (p1_r < lo1_r) || ({1'b0, p1_r} > ({1'b0, hi1_r} + TRAVEL_MARGIN));
  assign mismatch = ({1'b0, s0_r} > ({1'b0, s1_r} + SKEW_LIM)) ||
                    ({1'b0, s1_r} > ({1'b0, s0_r} + SKEW_LIM));
  assign bad      = travel || mismatch;
  assign f0       = bad ? '0 : s0_r;
  assign f1       = bad ? '0 : s1_r;
  assign avg      = {1'b0, f0[SCL_W-1:1]} + {1'b0, f1[SCL_W-1:1]};

  always_ff @(posedge clk) begin
    if (cmd.fault_eval) begin
      sf0_r   <= f0;
      sf1_r   <= f1;
      avg_r   <= avg;
      drive_r <= (avg >= DB_LVL);
    end
  end

  assign dmul = LIM_W'({{(LIM_W-SCL_W){1'b0}}, avg_r - DB_LVL} * LIM_W'(TORQUE_SCALE));

  always_comb begin
    if (drive_r) begin
      mul_a = 16'(dmul);
      mul_b = 16'(tlim_r);
    end else begin
      mul_a = gain_r;
      mul_b = front_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  assign regen_mag = {1'b0, prod_r} + (PROD_W+1)'(coast_r * 16'(TORQUE_SCALE));

  always_comb begin
    if (!ready_r) begin
      tq = '0;
    end else if (drive_r) begin
      tq = quotient[QUO_W-1] ? {1'b0, {(TQ_W-1){1'b1}}} : TQ_W'(quotient);
    end else if (regen_mag > (PROD_W+1)'(32768)) begin
      tq = {1'b1, {(TQ_W-1){1'b0}}};
    end else begin
      tq = TQ_W'(~regen_mag[TQ_W-1:0] + TQ_W'(1));
    end
  end

  assign bm0      = {{(BM_W-RAW_W){1'b0}}, b0_r} * PFS;
  assign bm1      = {{(BM_W-RAW_W){1'b0}}, b1_r} * PFS;
  assign bp0      = bm0[BM_W-1:ADC_SHIFT];
  assign bp1      = bm1[BM_W-1:ADC_SHIFT];
  assign bp_sum   = {1'b0, bp0} + {1'b0, bp1};
  assign trip_nxt = trip_r || (bp_sum[16:1] > trip_lvl_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trip_r <= 1'b0;
    end else if (cmd.out_load) begin
      trip_r <= trip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_first_pedal_scaled    <= sf0_r;
      out_second_pedal_scaled   <= sf1_r;
      out_first_brake_pressure  <= (bp0[15:BP_W] != '0) ? {BP_W{1'b1}} : bp0[BP_W-1:0];
      out_second_brake_pressure <= (bp1[15:BP_W] != '0) ? {BP_W{1'b1}} : bp1[BP_W-1:0];
      out_brake_tripped         <= trip_nxt;
      out_torque_command        <= signed'(tq);
      out_ready_echo            <= ready_r;
    end
  end

  assign sts.div_busy = div_busy;
  assign sts.drive    = drive_r;

endmodule

// File: rtl/core/ppt_ctrl.sv
// Controller FSM: sequences two pedal divisions, fault check, multiply,
// optional torque division and the output register handshake. Uses ppt_pkg.
module ppt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ppt_pkg::sts_t sts,
  output ppt_pkg::cmd_t cmd
);
  import ppt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_P0_GO;
      S_P0_GO:   state_nxt = S_P0_WAIT;
      S_P0_WAIT: if (!sts.div_busy) state_nxt = S_P1_GO;
      S_P1_GO:   state_nxt = S_P1_WAIT;
      S_P1_WAIT: if (!sts.div_busy) state_nxt = S_FAULT;
      S_FAULT:   state_nxt = S_MUL;
      S_MUL:     state_nxt = sts.drive ? S_TQ_GO : S_FINISH;
      S_TQ_GO:   state_nxt = S_TQ_WAIT;
      S_TQ_WAIT: if (!sts.div_busy) state_nxt = S_FINISH;
      S_FINISH:  if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = SEL_PEDAL0;
    in_ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_P0_GO: begin
        cmd.div_start = 1'b1;
      end
      S_P0_WAIT: begin
        cmd.store_s0 = !sts.div_busy;
      end
      S_P1_GO: begin
        cmd.div_sel   = SEL_PEDAL1;
        cmd.div_start = 1'b1;
      end
      S_P1_WAIT: begin
        cmd.div_sel  = SEL_PEDAL1;
        cmd.store_s1 = !sts.div_busy;
      end
      S_FAULT: begin
        cmd.fault_eval = 1'b1;
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
      end
      S_TQ_GO: begin
        cmd.div_sel   = SEL_TORQUE;
        cmd.div_start = 1'b1;
      end
      S_TQ_WAIT: begin
        cmd.div_sel = SEL_TORQUE;
      end
      S_FINISH: begin
        cmd.div_sel  = SEL_TORQUE;
        cmd.out_load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/pedal_plausibility_torque_command_unit.sv
// Pedal plausibility check and torque command, top level.
// Transactions are taken one at a time and run through the shared bit-serial divider:
// two 8-step pedal divisions, plus a 16-step torque division when driving.
// The result register frees the input side: a new transaction is taken while it waits.
// Synchronous active-low reset restores config defaults and clears the brake trip latch.
module pedal_plausibility_torque_command_unit #(
  parameter int PRESSURE_FULL_SCALE = ppt_pkg::PRESSURE_FULL_SCALE_DEF,
  parameter int PEDAL_SKEW          = ppt_pkg::PEDAL_SKEW_DEF,
  parameter int DEADBAND            = ppt_pkg::DEADBAND_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ppt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppt_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ppt_pkg::RAW_W-1:0]        in_first_pedal_raw,
  input  logic [ppt_pkg::RAW_W-1:0]        in_second_pedal_raw,
  input  logic [ppt_pkg::RAW_W-1:0]        in_first_brake_raw,
  input  logic [ppt_pkg::RAW_W-1:0]        in_second_brake_raw,
  input  logic [15:0]                      in_front_pressure,
  input  logic                             in_drive_ready,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ppt_pkg::SCL_W-1:0]        out_first_pedal_scaled,
  output logic [ppt_pkg::SCL_W-1:0]        out_second_pedal_scaled,
  output logic [ppt_pkg::BP_W-1:0]         out_first_brake_pressure,
  output logic [ppt_pkg::BP_W-1:0]         out_second_brake_pressure,
  output logic                             out_brake_tripped,
  output logic signed [ppt_pkg::TQ_W-1:0]  out_torque_command,
  output logic                             out_ready_echo
);
  import ppt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ppt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ppt_dp #(
    .PRESSURE_FULL_SCALE (PRESSURE_FULL_SCALE),
    .PEDAL_SKEW          (PEDAL_SKEW),
    .DEADBAND            (DEADBAND)
  ) u_dp (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cmd                       (cmd),
    .sts                       (sts),
    .cfg_we                    (cfg_we),
    .cfg_index                 (cfg_index),
    .cfg_wdata                 (cfg_wdata),
    .in_first_pedal_raw        (in_first_pedal_raw),
    .in_second_pedal_raw       (in_second_pedal_raw),
    .in_first_brake_raw        (in_first_brake_raw),
    .in_second_brake_raw       (in_second_brake_raw),
    .in_front_pressure         (in_front_pressure),
    .in_drive_ready            (in_drive_ready),
    .out_first_pedal_scaled    (out_first_pedal_scaled),
    .out_second_pedal_scaled   (out_second_pedal_scaled),
    .out_first_brake_pressure  (out_first_brake_pressure),
    .out_second_brake_pressure (out_second_brake_pressure),
    .out_brake_tripped         (out_brake_tripped),
    .out_torque_command        (out_torque_command),
    .out_ready_echo            (out_ready_echo)
  );

endmodule
